// File: rtl/mcs_pkg.sv
// Shared types and constants for the mask centroid steering block.
// No dependencies; imported by every module of the block.
package mcs_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CENTER_W = 11;
  localparam int unsigned VEL_W    = 28;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [PIX_W-1:0] MASK_SET = 8'hFF;

  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 12'd960;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 12'd540;
  localparam logic [GAIN_W-1:0] RST_ROTATE_GAIN  = 16'd328;
  localparam logic [GAIN_W-1:0] RST_FORWARD_GAIN = 16'd197;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROTATE_GAIN  = 2'd2,
    REG_FORWARD_GAIN = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SAT  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] rotate_gain;
    logic [GAIN_W-1:0] forward_gain;
  } gain_cfg_t;

endpackage

// File: rtl/mask_centroid_steering.sv
// Binary mask centroid and proportional steering.
// Pixel channel in: one 8-bit mask byte per beat, raster order; a byte of
// 255 marks an object pixel. Result channel out: one beat per frame with
// found flag, mean column/row and two saturated Q.16 velocities.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Configuration (frame size, gains) sits behind an APB port with
// registers at byte offsets 0, 4, 8 and 12; write only while idle.
// Throughput: one pixel per cycle. The front end only stalls when the
// two-entry frame queue is full.
// After a frame's last pixel is taken, its record is queued; the back end
// then pops it, divides one divide bit per cycle in the restoring divide
// loop (column and row share its divisor), multiplies and saturates. The
// back end takes a new frame only after the result beat is taken, so short
// frames backpressure the pixel stream once the frame queue is full.
// Reset clears the counters, accumulators, queue and output valid, and
// reloads the registers with 960, 540, 328 and 197.
// A stalled result holds its value; the next frame keeps accumulating
// until the queue fills.
module mask_centroid_steering import mcs_pkg::*; #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PIX_W-1:0]        mask_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    target_found_o,
  output logic [CENTER_W-1:0]     center_col_o,
  output logic [CENTER_W-1:0]     center_row_o,
  output logic signed [VEL_W-1:0] rotate_velocity_o,
  output logic signed [VEL_W-1:0] forward_velocity_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned CW   = $clog2(MAX_DIM);
  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned CNTW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned SUMW = CNTW + CW;
  localparam int unsigned RECW = 2 * SUMW + CNTW;

  logic [CFG_W-1:0]  fw_q, fh_q;
  logic [GAIN_W-1:0] rg_q, fg_q;
  logic [DW-1:0]     eff_w, eff_h;
  gain_cfg_t         gains;
  reg_idx_e          reg_idx;
  logic              wr_en;

  logic              pix_take, push, q_full, q_valid, q_pop;
  logic [RECW-1:0]   push_data, pop_data;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] d);
    if (d == '0) begin
      return DW'(1);
    end else if (32'(d) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(d);
    end
  endfunction

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= RST_FRAME_WIDTH;
      fh_q <= RST_FRAME_HEIGHT;
      rg_q <= RST_ROTATE_GAIN;
      fg_q <= RST_FORWARD_GAIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  fw_q <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[CFG_W-1:0];
        REG_ROTATE_GAIN:  rg_q <= pwdata[GAIN_W-1:0];
        REG_FORWARD_GAIN: fg_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(fw_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(fh_q);
      REG_ROTATE_GAIN:  prdata = APB_DW'(rg_q);
      REG_FORWARD_GAIN: prdata = APB_DW'(fg_q);
      default:          prdata = '0;
    endcase
  end

  assign eff_w              = eff_dim(fw_q);
  assign eff_h              = eff_dim(fh_q);
  assign gains.rotate_gain  = rg_q;
  assign gains.forward_gain = fg_q;

  assign in_stall_o = q_full;
  assign pix_take   = in_valid_i && !in_stall_o;

  mcs_front #(
    .CW(CW), .DW(DW), .CNTW(CNTW), .SUMW(SUMW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_take_i   (pix_take),
    .mask_value_i (mask_value_i),
    .eff_w_i      (eff_w),
    .eff_h_i      (eff_h),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  mcs_queue #(
    .WIDTH(RECW), .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  mcs_back #(
    .CW(CW), .DW(DW), .CNTW(CNTW), .SUMW(SUMW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (pop_data),
    .q_pop_o            (q_pop),
    .eff_w_i            (eff_w),
    .eff_h_i            (eff_h),
    .gains_i            (gains),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .target_found_o     (target_found_o),
    .center_col_o       (center_col_o),
    .center_row_o       (center_row_o),
    .rotate_velocity_o  (rotate_velocity_o),
    .forward_velocity_o (forward_velocity_o)
  );

endmodule

// File: rtl/mcs_front.sv
// Front end: pixel position counters and per-frame accumulators.
// Pushes one frame record per frame end. Uses mcs_pkg.
module mcs_front import mcs_pkg::*; #(
  parameter int unsigned CW   = 11,
  parameter int unsigned DW   = 12,
  parameter int unsigned CNTW = 23,
  parameter int unsigned SUMW = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_take_i,
  input  logic [PIX_W-1:0]              mask_value_i,
  input  logic [DW-1:0]                 eff_w_i,
  input  logic [DW-1:0]                 eff_h_i,
  output logic                          push_o,
  output logic [2*SUMW+CNTW-1:0]        push_data_o
);

  logic [CW-1:0]   col_q, col_d, row_q, row_d;
  logic [SUMW-1:0] csum_q, csum_d, rsum_q, rsum_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SUMW-1:0] csum_add, rsum_add;
  logic [CNTW-1:0] cnt_add;
  logic            is_set, row_end, frame_end;

  assign is_set    = (mask_value_i == MASK_SET);
  assign row_end   = ((DW'(col_q) + DW'(1)) >= eff_w_i);
  assign frame_end = row_end && ((DW'(row_q) + DW'(1)) >= eff_h_i);

  assign csum_add = is_set ? (csum_q + SUMW'(col_q)) : csum_q;
  assign rsum_add = is_set ? (rsum_q + SUMW'(row_q)) : rsum_q;
  assign cnt_add  = is_set ? (cnt_q + CNTW'(1)) : cnt_q;

  assign push_o      = pix_take_i && frame_end;
  assign push_data_o = {csum_add, rsum_add, cnt_add};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    csum_d = csum_q;
    rsum_d = rsum_q;
    cnt_d  = cnt_q;
    if (pix_take_i) begin
      if (frame_end) begin
        col_d  = '0;
        row_d  = '0;
        csum_d = '0;
        rsum_d = '0;
        cnt_d  = '0;
      end else begin
        csum_d = csum_add;
        rsum_d = rsum_add;
        cnt_d  = cnt_add;
        if (row_end) begin
          col_d = '0;
          row_d = row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      csum_q <= '0;
      rsum_q <= '0;
      cnt_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      csum_q <= csum_d;
      rsum_q <= rsum_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/mcs_queue.sv
// Small register FIFO that decouples the front end from the back end.
// Generic width and depth; uses mcs_pkg for house consistency only.
module mcs_queue import mcs_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == NW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/mcs_back.sv
// Back end: per-frame restoring divides, gain multiply, saturation and
// the registered result beat. Uses mcs_pkg.
module mcs_back import mcs_pkg::*; #(
  parameter int unsigned CW   = 11,
  parameter int unsigned DW   = 12,
  parameter int unsigned CNTW = 23,
  parameter int unsigned SUMW = 34
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  logic [2*SUMW+CNTW-1:0]      q_data_i,
  output logic                        q_pop_o,
  input  logic [DW-1:0]               eff_w_i,
  input  logic [DW-1:0]               eff_h_i,
  input  gain_cfg_t                   gains_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        target_found_o,
  output logic [CENTER_W-1:0]         center_col_o,
  output logic [CENTER_W-1:0]         center_row_o,
  output logic signed [VEL_W-1:0]     rotate_velocity_o,
  output logic signed [VEL_W-1:0]     forward_velocity_o
);

  localparam int unsigned EW  = CW + 2;
  localparam int unsigned PRW = EW + GAIN_W + 1;
  localparam int unsigned XW  = (PRW > VEL_W) ? PRW : VEL_W + 1;
  localparam int unsigned BW  = $clog2(CW);
  localparam logic signed [XW-1:0] VMAX = XW'((64'sd1 <<< (VEL_W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);

  back_state_e state_q, state_d;

  logic [SUMW-1:0]       remc_q, remc_d, remr_q, remr_d, ds_q, ds_d;
  logic [CW-1:0]         qc_q, qc_d, qr_q, qr_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic signed [PRW-1:0] pc_q, pc_d, pr_q, pr_d;
  logic                  found_q, found_d;
  logic [CENTER_W-1:0]   ccol_q, ccol_d, crow_q, crow_d;
  logic signed [VEL_W-1:0] rvel_q, rvel_d, fvel_q, fvel_d;

  logic [SUMW-1:0]       in_csum, in_rsum;
  logic [CNTW-1:0]       in_cnt;
  logic                  ge_c, ge_r;
  logic signed [EW-1:0]  err_c, err_r;
  logic signed [XW-1:0]  pcx, prx;

  assign {in_csum, in_rsum, in_cnt} = q_data_i;

  assign ge_c  = (remc_q >= ds_q);
  assign ge_r  = (remr_q >= ds_q);
  assign err_c = $signed(EW'(eff_w_i >> 1)) - $signed(EW'(qc_q));
  assign err_r = $signed(EW'(eff_h_i >> 1)) - $signed(EW'(qr_q));
  assign pcx   = XW'(pc_q);
  assign prx   = XW'(pr_q);

  assign q_pop_o     = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;

  always_comb begin
    state_d = state_q;
    remc_d  = remc_q;
    remr_d  = remr_q;
    ds_d    = ds_q;
    qc_d    = qc_q;
    qr_d    = qr_q;
    bit_d   = bit_q;
    pc_d    = pc_q;
    pr_d    = pr_q;
    found_d = found_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    rvel_d  = rvel_q;
    fvel_d  = fvel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          remc_d = in_csum;
          remr_d = in_rsum;
          ds_d   = SUMW'(in_cnt) << (CW - 1);
          qc_d   = '0;
          qr_d   = '0;
          bit_d  = BW'(CW - 1);
          if (in_cnt != '0) begin
            state_d = ST_DIV;
          end else begin
            // empty frame: all-zero result
            found_d = 1'b0;
            ccol_d  = '0;
            crow_d  = '0;
            rvel_d  = '0;
            fvel_d  = '0;
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (ge_c) remc_d = remc_q - ds_q;
        if (ge_r) remr_d = remr_q - ds_q;
        qc_d  = {qc_q[CW-2:0], ge_c};
        qr_d  = {qr_q[CW-2:0], ge_r};
        ds_d  = ds_q >> 1;
        bit_d = bit_q - BW'(1);
        if (bit_q == '0) state_d = ST_MUL;
      end
      ST_MUL: begin
        pc_d    = err_c * $signed({1'b0, gains_i.rotate_gain});
        pr_d    = err_r * $signed({1'b0, gains_i.forward_gain});
        state_d = ST_SAT;
      end
      ST_SAT: begin
        found_d = 1'b1;
        ccol_d  = CENTER_W'(qc_q);
        crow_d  = CENTER_W'(qr_q);
        if (pcx > VMAX)      rvel_d = VEL_W'(VMAX);
        else if (pcx < VMIN) rvel_d = VEL_W'(VMIN);
        else                 rvel_d = VEL_W'(pcx);
        if (prx > VMAX)      fvel_d = VEL_W'(VMAX);
        else if (prx < VMIN) fvel_d = VEL_W'(VMIN);
        else                 fvel_d = VEL_W'(prx);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    remc_q  <= remc_d;
    remr_q  <= remr_d;
    ds_q    <= ds_d;
    qc_q    <= qc_d;
    qr_q    <= qr_d;
    bit_q   <= bit_d;
    pc_q    <= pc_d;
    pr_q    <= pr_d;
    found_q <= found_d;
    ccol_q  <= ccol_d;
    crow_q  <= crow_d;
    rvel_q  <= rvel_d;
    fvel_q  <= fvel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign target_found_o     = found_q;
  assign center_col_o       = ccol_q;
  assign center_row_o       = crow_q;
  assign rotate_velocity_o  = rvel_q;
  assign forward_velocity_o = fvel_q;

endmodule

// File: rtl/mcs_checker.sv
// Port-level checks for mask_centroid_steering, bound to the top level.
// Uses mcs_pkg for field widths.
module mcs_checker import mcs_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [PIX_W-1:0]        mask_value_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    target_found_o,
  input logic [CENTER_W-1:0]     center_col_o,
  input logic [CENTER_W-1:0]     center_row_o,
  input logic signed [VEL_W-1:0] rotate_velocity_o,
  input logic signed [VEL_W-1:0] forward_velocity_o,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [APB_AW-1:0]       paddr,
  input logic [APB_DW-1:0]       pwdata,
  input logic [APB_DW-1:0]       prdata,
  input logic                    pready
);

  // result beat stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(target_found_o) && $stable(center_col_o) && $stable(center_row_o) &&
      $stable(rotate_velocity_o) && $stable(forward_velocity_o))
    else $error("stalled result changed");

  // empty frame reports all zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !target_found_o |->
      center_col_o == '0 && center_row_o == '0 &&
      rotate_velocity_o == '0 && forward_velocity_o == '0)
    else $error("empty frame result not zero");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind mask_centroid_steering mcs_checker u_mcs_checker (.*);
